@@ rtl/core/sri_pkg.sv @@
package sri_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int NUM_EDGES  = 4;
  localparam int NUM_REGS   = 4;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int ADDR_W     = REG_IDX_W + 2;
  localparam int DATA_W     = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CORNER_A_X,
    REG_CORNER_A_Y,
    REG_CORNER_B_X,
    REG_CORNER_B_Y
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
  } rect_t;

  // per edge: edge direction and segment start relative to edge start
  typedef struct packed {
    logic signed [DIFF_W-1:0] s2x;
    logic signed [DIFF_W-1:0] s2y;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } edge_geo_t;

  typedef struct packed {
    logic mul;
    logic sum;
  } adv_t;

endpackage

@@ rtl/core/segment_rectangle_intersect.sv @@
// stages: input differences, products (24 parallel 17x17 multipliers), cross products, hits
// throughput: one segment per cycle while hit_stall is low; stage 2, products, sets the pace
// each stage loads when empty or when the stage after it moves, so bubbles collapse
// reset: clears every stage valid and sets all four corner registers to zero
module segment_rectangle_intersect (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sri_pkg::ADDR_W-1:0]         paddr,
  input  logic [sri_pkg::DATA_W-1:0]         pwdata,
  output logic [sri_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               seg_valid,
  output logic                               seg_stall,
  input  logic signed [sri_pkg::COORD_BITS-1:0] seg_start_x,
  input  logic signed [sri_pkg::COORD_BITS-1:0] seg_start_y,
  input  logic signed [sri_pkg::COORD_BITS-1:0] seg_end_x,
  input  logic signed [sri_pkg::COORD_BITS-1:0] seg_end_y,
  output logic                               hit_valid,
  input  logic                               hit_stall,
  output logic                               hits
);
  import sri_pkg::*;

  rect_t rect;

  logic signed [COORD_BITS-1:0] lx, hx, ly, hy;
  logic                         in_s, in_e;

  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4;
  adv_t adv;

  logic signed [DIFF_W-1:0] s1x, s1y;
  edge_geo_t                geo [NUM_EDGES];
  edge_geo_t                geo_next [NUM_EDGES];
  logic                     ins1, ins2, ins3;
  logic [NUM_EDGES-1:0]     edge_hits;

  sri_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rect    (rect)
  );

  // order the corners
  assign lx = (rect.ax < rect.bx) ? rect.ax : rect.bx;
  assign hx = (rect.ax < rect.bx) ? rect.bx : rect.ax;
  assign ly = (rect.ay < rect.by) ? rect.ay : rect.by;
  assign hy = (rect.ay < rect.by) ? rect.by : rect.ay;

  assign in_s = (seg_start_x >= lx) && (seg_start_x <= hx) &&
                (seg_start_y >= ly) && (seg_start_y <= hy);
  assign in_e = (seg_end_x >= lx) && (seg_end_x <= hx) &&
                (seg_end_y >= ly) && (seg_end_y <= hy);

  // edges in order bottom, right, top, left
  always_comb begin
    geo_next[0].s2x = DIFF_W'(hx) - DIFF_W'(lx);
    geo_next[0].s2y = '0;
    geo_next[0].dx  = DIFF_W'(seg_start_x) - DIFF_W'(lx);
    geo_next[0].dy  = DIFF_W'(seg_start_y) - DIFF_W'(ly);
    geo_next[1].s2x = '0;
    geo_next[1].s2y = DIFF_W'(hy) - DIFF_W'(ly);
    geo_next[1].dx  = DIFF_W'(seg_start_x) - DIFF_W'(hx);
    geo_next[1].dy  = DIFF_W'(seg_start_y) - DIFF_W'(ly);
    geo_next[2].s2x = DIFF_W'(lx) - DIFF_W'(hx);
    geo_next[2].s2y = '0;
    geo_next[2].dx  = DIFF_W'(seg_start_x) - DIFF_W'(hx);
    geo_next[2].dy  = DIFF_W'(seg_start_y) - DIFF_W'(hy);
    geo_next[3].s2x = '0;
    geo_next[3].s2y = DIFF_W'(ly) - DIFF_W'(hy);
    geo_next[3].dx  = DIFF_W'(seg_start_x) - DIFF_W'(lx);
    geo_next[3].dy  = DIFF_W'(seg_start_y) - DIFF_W'(hy);
  end

  // stage handshake
  assign ready4    = !v4 || !hit_stall;
  assign ready3    = !v3 || ready4;
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign seg_stall = !ready1;
  assign adv.mul   = ready2;
  assign adv.sum   = ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready1) v1 <= seg_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1x  <= DIFF_W'(seg_end_x) - DIFF_W'(seg_start_x);
      s1y  <= DIFF_W'(seg_end_y) - DIFF_W'(seg_start_y);
      ins1 <= in_s || in_e;
      for (int i = 0; i < NUM_EDGES; i++) begin
        geo[i] <= geo_next[i];
      end
    end
    if (ready2) ins2 <= ins1;
    if (ready3) ins3 <= ins2;
    if (ready4) hits <= ins3 || (|edge_hits);
  end

  for (genvar g = 0; g < NUM_EDGES; g++) begin : g_edge
    sri_edge u_edge (
      .clk      (clk),
      .adv      (adv),
      .s1x      (s1x),
      .s1y      (s1y),
      .geo      (geo[g]),
      .edge_hit (edge_hits[g])
    );
  end

  assign hit_valid = v4;

  // input only held off when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    seg_stall |-> (v1 && v2 && v3 && v4))
    else $error("segment stalled with an empty stage");

  // an item blocked in stage 1 stays there
  a_hold_s1: assert property (@(posedge clk) disable iff (rst)
    (v1 && !ready2) |=> v1)
    else $error("stage 1 item dropped while blocked");

  // a stage 3 item moves forward when the output side is free
  a_move_s3: assert property (@(posedge clk) disable iff (rst)
    (v3 && ready4) |=> v4)
    else $error("stage 3 item lost on advance");

  a_reset: assert property (@(posedge clk)
    rst |=> (!hit_valid && !seg_stall))
    else $error("pipeline not empty after reset");

endmodule

@@ rtl/core/sri_cfg.sv @@
module sri_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sri_pkg::ADDR_W-1:0]   paddr,
  input  logic [sri_pkg::DATA_W-1:0]   pwdata,
  output logic [sri_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output sri_pkg::rect_t               rect
);
  import sri_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect <= '0;
    end else if (wr) begin
      case (idx)
        REG_CORNER_A_X: rect.ax <= pwdata[COORD_BITS-1:0];
        REG_CORNER_A_Y: rect.ay <= pwdata[COORD_BITS-1:0];
        REG_CORNER_B_X: rect.bx <= pwdata[COORD_BITS-1:0];
        REG_CORNER_B_Y: rect.by <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CORNER_A_X: prdata = DATA_W'($unsigned(rect.ax));
      REG_CORNER_A_Y: prdata = DATA_W'($unsigned(rect.ay));
      REG_CORNER_B_X: prdata = DATA_W'($unsigned(rect.bx));
      REG_CORNER_B_Y: prdata = DATA_W'($unsigned(rect.by));
      default:        prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/sri_edge.sv @@
module sri_edge (
  input  logic                               clk,
  input  sri_pkg::adv_t                      adv,
  input  logic signed [sri_pkg::DIFF_W-1:0]  s1x,
  input  logic signed [sri_pkg::DIFF_W-1:0]  s1y,
  input  sri_pkg::edge_geo_t                 geo,
  output logic                               edge_hit
);
  import sri_pkg::*;

  logic signed [DIFF_W-1:0] s2x, s2y, dx, dy;
  logic signed [PROD_W-1:0] p_a, p_b, p_c, p_d, p_e, p_f;
  logic signed [SUM_W-1:0]  den, ns, nt;
  logic                     pos_ok, neg_ok;

  assign s2x = geo.s2x;
  assign s2y = geo.s2y;
  assign dx  = geo.dx;
  assign dy  = geo.dy;

  // product stage
  always_ff @(posedge clk) begin
    if (adv.mul) begin
      p_a <= PROD_W'(s1x) * PROD_W'(s2y);
      p_b <= PROD_W'(s2x) * PROD_W'(s1y);
      p_c <= PROD_W'(s1x) * PROD_W'(dy);
      p_d <= PROD_W'(s1y) * PROD_W'(dx);
      p_e <= PROD_W'(s2x) * PROD_W'(dy);
      p_f <= PROD_W'(s2y) * PROD_W'(dx);
    end
  end

  // cross product stage
  always_ff @(posedge clk) begin
    if (adv.sum) begin
      den <= SUM_W'(p_a) - SUM_W'(p_b);
      ns  <= SUM_W'(p_c) - SUM_W'(p_d);
      nt  <= SUM_W'(p_e) - SUM_W'(p_f);
    end
  end

  // 0 <= n/den <= 1 without dividing; sign of den picks the bound direction
  assign pos_ok   = (ns >= 0) && (ns <= den) && (nt >= 0) && (nt <= den);
  assign neg_ok   = (ns <= 0) && (ns >= den) && (nt <= 0) && (nt >= den);
  assign edge_hit = (den > 0) ? pos_ok : ((den < 0) ? neg_ok : 1'b0);

endmodule

@@ tb/sv/sri_hit_checker.sv @@
module sri_hit_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic                                  pready,
  input  logic [sri_pkg::ADDR_W-1:0]            paddr,
  input  logic [sri_pkg::DATA_W-1:0]            pwdata,
  input  logic                                  seg_valid,
  input  logic                                  seg_stall,
  input  logic signed [sri_pkg::COORD_BITS-1:0] seg_start_x,
  input  logic signed [sri_pkg::COORD_BITS-1:0] seg_start_y,
  input  logic signed [sri_pkg::COORD_BITS-1:0] seg_end_x,
  input  logic signed [sri_pkg::COORD_BITS-1:0] seg_end_y,
  input  logic                                  hit_valid,
  input  logic                                  hit_stall,
  input  logic                                  hits,
  output int                                    hits_pending,
  output int                                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import sri_pkg::*;

  typedef struct {
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic                         hit;
  } hit_expect_t;

  rect_t       rect_cfg;
  hit_expect_t expected_hits[$];
  int          mismatches = 0;

  initial begin
    hits_pending = 0;
    fail_count   = 0;
  end

  // segment p0->p1 against edge p2->p3, cross-product form without division
  function automatic logic crosses_edge(longint p0x, longint p0y, longint p1x, longint p1y,
                                        longint p2x, longint p2y, longint p3x, longint p3y);
    longint s1x, s1y, s2x, s2y, dx, dy, den, ns, nt;
    s1x = p1x - p0x;
    s1y = p1y - p0y;
    s2x = p3x - p2x;
    s2y = p3y - p2y;
    dx  = p0x - p2x;
    dy  = p0y - p2y;
    den = s1x * s2y - s2x * s1y;
    ns  = s1x * dy - s1y * dx;
    nt  = s2x * dy - s2y * dx;
    // parallel or zero length never crosses
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den;
      ns  = -ns;
      nt  = -nt;
    end
    return ns >= 0 && ns <= den && nt >= 0 && nt <= den;
  endfunction

  function automatic logic segment_hits_rect(rect_t r,
                                             logic signed [COORD_BITS-1:0] sx,
                                             logic signed [COORD_BITS-1:0] sy,
                                             logic signed [COORD_BITS-1:0] ex,
                                             logic signed [COORD_BITS-1:0] ey);
    longint ax, ay, bx, by, lx, hx, ly, hy, x0, y0, x1, y1;
    ax = r.ax;
    ay = r.ay;
    bx = r.bx;
    by = r.by;
    lx = (ax < bx) ? ax : bx;
    hx = (ax < bx) ? bx : ax;
    ly = (ay < by) ? ay : by;
    hy = (ay < by) ? by : ay;
    x0 = sx;
    y0 = sy;
    x1 = ex;
    y1 = ey;
    if ((x0 >= lx && x0 <= hx && y0 >= ly && y0 <= hy) ||
        (x1 >= lx && x1 <= hx && y1 >= ly && y1 <= hy))
      return 1'b1;
    // bottom, right, top, left
    return crosses_edge(x0, y0, x1, y1, lx, ly, hx, ly) ||
           crosses_edge(x0, y0, x1, y1, hx, ly, hx, hy) ||
           crosses_edge(x0, y0, x1, y1, hx, hy, lx, hy) ||
           crosses_edge(x0, y0, x1, y1, lx, hy, lx, ly);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    // keep the log short when the block is badly broken
    if (mismatches <= 200) $display("%0t hits check failed: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    hit_expect_t want;
    if (rst) begin
      rect_cfg = '0;
      expected_hits.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_CORNER_A_X: rect_cfg.ax = pwdata[COORD_BITS-1:0];
          REG_CORNER_A_Y: rect_cfg.ay = pwdata[COORD_BITS-1:0];
          REG_CORNER_B_X: rect_cfg.bx = pwdata[COORD_BITS-1:0];
          REG_CORNER_B_Y: rect_cfg.by = pwdata[COORD_BITS-1:0];
          default: ;
        endcase
      end
      if (seg_valid && !seg_stall) begin
        want.sx  = seg_start_x;
        want.sy  = seg_start_y;
        want.ex  = seg_end_x;
        want.ey  = seg_end_y;
        want.hit = segment_hits_rect(rect_cfg, seg_start_x, seg_start_y,
                                     seg_end_x, seg_end_y);
        expected_hits.push_back(want);
      end
      if (hit_valid && !hit_stall) begin
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("hits beat %0b with no segment outstanding", hits));
        end else begin
          want = expected_hits.pop_front();
          if (hits !== want.hit)
            report_mismatch($sformatf(
              "seg (%0d,%0d)->(%0d,%0d) rect (%0d,%0d)/(%0d,%0d) got %b want %b",
              want.sx, want.sy, want.ex, want.ey, rect_cfg.ax,
              rect_cfg.ay, rect_cfg.bx, rect_cfg.by, hits, want.hit));
        end
      end
    end
    hits_pending <= expected_hits.size();
    fail_count   <= mismatches;
  end

endmodule

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sri_pkg::*;

  localparam int RAND_PHASES    = 8;
  localparam int SEGS_PER_PHASE = 228;

  logic                         clk         = 1'b0;
  logic                         rst         = 1'b1;
  logic                         psel        = 1'b0;
  logic                         penable     = 1'b0;
  logic                         pwrite      = 1'b0;
  logic [ADDR_W-1:0]            paddr       = '0;
  logic [DATA_W-1:0]            pwdata      = '0;
  logic [DATA_W-1:0]            prdata;
  logic                         pready;
  logic                         seg_valid   = 1'b0;
  logic                         seg_stall;
  logic signed [COORD_BITS-1:0] seg_start_x = '0;
  logic signed [COORD_BITS-1:0] seg_start_y = '0;
  logic signed [COORD_BITS-1:0] seg_end_x   = '0;
  logic signed [COORD_BITS-1:0] seg_end_y   = '0;
  logic                         hit_valid;
  logic                         hit_stall   = 1'b0;
  logic                         hits;
  int                           hits_pending;
  int                           fail_count;

  // no idling on either side while set
  logic calm = 1'b0;
  // ordered rectangle bounds, used to aim segments near it
  int   lo_x = 0, hi_x = 0, lo_y = 0, hi_y = 0;

  segment_rectangle_intersect dut (.*);
  sri_hit_checker u_checker (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(negedge clk) hit_stall = !rst && !calm && ($urandom_range(99) < 34);

  function automatic int clamp_coord(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int near_coord(int lo, int hi);
    int m;
    m = (hi - lo) / 2 + 8;
    case ($urandom_range(5))
      0: return lo;
      1: return hi;
      2: return clamp_coord($urandom_range(1) ? lo - 1 : hi + 1);
      default: return clamp_coord(lo - m + int'($urandom_range(hi - lo + 2 * m)));
    endcase
  endfunction

  task automatic write_reg(reg_idx_t idx, int value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    // upper bits are junk the block must ignore
    pwdata  = {16'($urandom), 16'(value)};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    seg_valid = 1'b0;
    while (hits_pending != 0) @(posedge clk);
  endtask

  task automatic load_rect(int ax, int ay, int bx, int by);
    wait_drained();
    // let the pipeline settle past its latency
    repeat (6) @(posedge clk);
    write_reg(REG_CORNER_A_X, ax);
    write_reg(REG_CORNER_A_Y, ay);
    write_reg(REG_CORNER_B_X, bx);
    write_reg(REG_CORNER_B_Y, by);
    lo_x = (ax < bx) ? ax : bx;
    hi_x = (ax < bx) ? bx : ax;
    lo_y = (ay < by) ? ay : by;
    hi_y = (ay < by) ? by : ay;
  endtask

  task automatic send_segment(int sx, int sy, int ex, int ey);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 34) begin
      seg_valid = 1'b0;
      @(negedge clk);
    end
    seg_valid   = 1'b1;
    seg_start_x = COORD_BITS'(sx);
    seg_start_y = COORD_BITS'(sy);
    seg_end_x   = COORD_BITS'(ex);
    seg_end_y   = COORD_BITS'(ey);
    do @(posedge clk); while (seg_stall);
  endtask

  task automatic random_rect();
    int cx, cy, w, h;
    cx = any_coord();
    cy = any_coord();
    case ($urandom_range(3))
      0: begin
        w = $urandom_range(64);
        h = $urandom_range(64);
      end
      1: begin
        w = $urandom_range(4000);
        h = $urandom_range(4000);
      end
      2: begin
        w = any_coord() - cx;
        h = any_coord() - cy;
      end
      default: begin
        // zero width or zero height
        w = $urandom_range(1) ? 0 : $urandom_range(2000);
        h = (w == 0) ? $urandom_range(2000) : 0;
      end
    endcase
    if ($urandom_range(1)) w = -w;
    if ($urandom_range(1)) h = -h;
    load_rect(cx, cy, clamp_coord(cx + w), clamp_coord(cy + h));
  endtask

  task automatic random_segment();
    int sx, sy, ex, ey;
    case ($urandom_range(9))
      0: begin
        sx = any_coord();
        sy = any_coord();
        ex = any_coord();
        ey = any_coord();
      end
      1: begin
        sx = near_coord(lo_x, hi_x);
        sy = near_coord(lo_y, hi_y);
        ex = sx;
        ey = sy;
      end
      2: begin
        sx = near_coord(lo_x, hi_x);
        ex = near_coord(lo_x, hi_x);
        sy = near_coord(lo_y, hi_y);
        ey = sy;
      end
      3: begin
        sy = near_coord(lo_y, hi_y);
        ey = near_coord(lo_y, hi_y);
        sx = near_coord(lo_x, hi_x);
        ex = sx;
      end
      default: begin
        sx = near_coord(lo_x, hi_x);
        sy = near_coord(lo_y, hi_y);
        ex = near_coord(lo_x, hi_x);
        ey = near_coord(lo_y, hi_y);
      end
    endcase
    send_segment(sx, sy, ex, ey);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset rectangle is a single point at the origin
    send_segment(0, 0, 0, 0);
    send_segment(-5, -5, 5, 5);
    send_segment(0, 0, 32767, -32768);

    // corners given high first, block must order them
    load_rect(200, 150, -100, -50);
    send_segment(0, 0, 10, 10);
    send_segment(-100, -50, -1000, -1000);
    send_segment(500, 500, 200, 100);
    send_segment(-300, 0, 300, 0);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(-300, -300, -200, 300);
    send_segment(-300, 200, 300, 200);
    send_segment(-300, -50, 300, -50);
    send_segment(-200, 50, 0, -150);
    send_segment(500, 500, 500, 500);
    send_segment(-101, -300, -101, 300);
    send_segment(32767, 32767, 32767, -32768);
    send_segment(-32768, -32768, -32768, 32767);
    send_segment(-32768, 0, 32767, 0);

    load_rect(-32768, 32767, 32767, -32768);
    send_segment(32767, 32767, 32767, 32767);
    send_segment(-32768, -32768, 32767, -32768);

    // zero-width rectangle: collinear segment misses, crossing one hits
    load_rect(50, 20, 50, -20);
    send_segment(0, 0, 100, 0);
    send_segment(50, -100, 50, 100);
    send_segment(50, 0, 50, 0);

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == 0)
        load_rect(32767, -32768, 32767 - int'($urandom_range(3000)),
                  -32768 + int'($urandom_range(3000)));
      else
        random_rect();
      calm = (phase == 3);
      for (int i = 0; i < SEGS_PER_PHASE; i++) begin
        if (phase == 5 && i % 40 == 39) wait_drained();
        random_segment();
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && hits_pending == 0)
      $display("[segment_rectangle_intersect] OK");
    else
      $display("[segment_rectangle_intersect] ERROR");
    $finish;
  end

  initial begin
    #3ms;
    $display("[segment_rectangle_intersect] ERROR");
    $finish;
  end

endmodule
